### src/csl_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// csl_pkg: shared types and constants of the chunk slot lookup
// Table sizes, field widths, the item carried between front and back, the
// state encodings and the remainder step of the bucket hash.
// ----------------------------------------------------------------------------
package csl_pkg;

  // Table geometry.
  localparam int CHUNK_BITS = 8;
  localparam int BUCKETS    = 1021;
  localparam int SLOTS      = 4096;

  // Field widths.
  localparam int COORD_W = 32;
  localparam int KEY_W   = 24;
  localparam int OFF_W   = 8;
  localparam int SLOT_W  = $clog2(SLOTS + 1);
  localparam int SLOT_AW = $clog2(SLOTS);
  localparam int BKT_W   = $clog2(BUCKETS);
  localparam int SLOT_DW = SLOT_W + 2 * KEY_W;

  // Hash remainder unit: the product is reduced one digit per cycle.
  localparam int PROD_W    = 2 * KEY_W;
  localparam int DIG_W     = 8;
  localparam int NDIG      = PROD_W / DIG_W;
  localparam int DIG_CNT_W = $clog2(NDIG);
  localparam int RED_W     = BKT_W + DIG_W;

  // Queue between front and back.
  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Mask that keeps the in-chunk offset of a coordinate.
  localparam logic [COORD_W-1:0] OFF_MASK = COORD_W'((64'd1 << CHUNK_BITS) - 64'd1);

  // A multiple of BUCKETS that is at least the largest product magnitude.
  // Adding it makes the product non-negative without changing its residue.
  localparam longint unsigned BIAS_Q =
    ((64'd1 << (PROD_W - 2)) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS);
  localparam logic [PROD_W-1:0] HASH_BIAS = PROD_W'(BIAS_Q * 64'(BUCKETS));

  // One classified item, as handed from front to back.
  typedef struct packed {
    logic [KEY_W-1:0] kx;
    logic [KEY_W-1:0] ky;
    logic [OFF_W-1:0] ox;
    logic [OFF_W-1:0] oy;
    logic [BKT_W-1:0] bucket;
  } csl_item_t;

  typedef enum logic [2:0] {
    F_IDLE,
    F_MUL,
    F_BIAS,
    F_RED,
    F_PUSH
  } front_state_t;

  typedef enum logic [2:0] {
    B_CLEAR,
    B_IDLE,
    B_HEAD,
    B_SLOT,
    B_ALLOC,
    B_LINK,
    B_DONE
  } back_state_t;

  // Shifts one digit into a remainder below BUCKETS and reduces it again.
  function automatic logic [BKT_W-1:0] mod_step(input logic [BKT_W-1:0] rem,
                                                input logic [DIG_W-1:0] dig);
    logic [RED_W-1:0] t;
    t = {rem, dig};
    for (int k = DIG_W - 1; k >= 0; k--) begin
      if (t >= (RED_W'(BUCKETS) << k)) begin
        t = t - (RED_W'(BUCKETS) << k);
      end
    end
    return t[BKT_W-1:0];
  endfunction

  // A slot reference that a chain walk may follow.
  function automatic logic link_ok(input logic [SLOT_W-1:0] s);
    return (s != '0) && (s <= SLOT_W'(SLOTS));
  endfunction

endpackage
`default_nettype wire

### src/chunk_slot_lookup.sv
`default_nettype none
// ----------------------------------------------------------------------------
// chunk_slot_lookup: chunk slot table lookup and insert
// Splits a pixel coordinate into chunk key and offsets, hashes the key to a
// bucket and finds or allocates the chunk's slot in a chained table.
// ----------------------------------------------------------------------------
// Throughput: set by the front's six-digit hash remainder unit, which takes
//   a new item only while handing the last one over, or by the back when
//   slower; the back reads chain links one per cycle, and a miss adds the
//   allocation and the link of a new slot.
// A flush adds a sweep of the bucket heads to that item.
// Reset: a sweep clears the bucket heads; full stays high meanwhile.
module chunk_slot_lookup import csl_pkg::*; (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_push,
  output logic                           in_full,
  input  wire logic signed [COORD_W-1:0] in_pixel_x,
  input  wire logic signed [COORD_W-1:0] in_pixel_y,
  output logic                           out_empty,
  input  wire logic                      out_pop,
  output logic [SLOT_W-1:0]              out_slot_index,
  output logic                           out_was_present,
  output logic                           out_table_flushed,
  output logic signed [KEY_W-1:0]        out_chunk_x,
  output logic signed [KEY_W-1:0]        out_chunk_y,
  output logic [OFF_W-1:0]               out_offset_x,
  output logic [OFF_W-1:0]               out_offset_y
);

  logic      init_busy;
  logic      fq_push, fq_full;
  csl_item_t fq_item;
  logic      qb_valid, qb_pop;
  csl_item_t qb_item;

  // Front: split and hash.
  csl_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_push    (in_push),
    .in_full    (in_full),
    .in_pixel_x (in_pixel_x),
    .in_pixel_y (in_pixel_y),
    .init_busy  (init_busy),
    .q_push     (fq_push),
    .q_item     (fq_item),
    .q_full     (fq_full)
  );

  // Queue of hashed items.
  csl_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (fq_push),
    .full     (fq_full),
    .item_in  (fq_item),
    .valid    (qb_valid),
    .pop      (qb_pop),
    .item_out (qb_item)
  );

  // Back: chain walk, allocation and result register.
  csl_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_valid           (qb_valid),
    .q_pop             (qb_pop),
    .q_item            (qb_item),
    .init_busy         (init_busy),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_slot_index    (out_slot_index),
    .out_was_present   (out_was_present),
    .out_table_flushed (out_table_flushed),
    .out_chunk_x       (out_chunk_x),
    .out_chunk_y       (out_chunk_y),
    .out_offset_x      (out_offset_x),
    .out_offset_y      (out_offset_y)
  );

endmodule
`default_nettype wire

### src/csl_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// csl_ram: generic simple dual-port RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module csl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

### src/csl_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// csl_front: coordinate split and bucket hash
// Accepts one pixel item, splits it into chunk key and offsets, forms the
// key product and reduces it modulo BUCKETS one digit per cycle.
// ----------------------------------------------------------------------------
module csl_front import csl_pkg::*; (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_push,
  output logic                           in_full,
  input  wire logic signed [COORD_W-1:0] in_pixel_x,
  input  wire logic signed [COORD_W-1:0] in_pixel_y,
  input  wire logic                      init_busy,
  output logic                           q_push,
  output csl_item_t                      q_item,
  input  wire logic                      q_full
);

  front_state_t state_r, state_nxt;
  logic [DIG_CNT_W-1:0] dig_r, dig_nxt;

  logic signed [KEY_W-1:0]  kx_r, ky_r;
  logic [OFF_W-1:0]         ox_r, oy_r;
  logic signed [PROD_W-1:0] prod_r;
  logic [PROD_W-1:0]        u_r;
  logic [BKT_W-1:0]         rem_r;

  logic                      accept;
  logic signed [COORD_W-1:0] shift_x, shift_y;
  logic [COORD_W-1:0]        mask_x, mask_y;

  // The front takes an item when idle, or while handing the last one over.
  always_comb begin
    in_full = 1'b1;
    if (!init_busy) begin
      if (state_r == F_IDLE) begin
        in_full = 1'b0;
      end else if (state_r == F_PUSH && !q_full) begin
        in_full = 1'b0;
      end
    end
  end

  assign accept = in_push && !in_full;

  // Floor division by the chunk size is an arithmetic shift.
  assign shift_x = in_pixel_x >>> CHUNK_BITS;
  assign shift_y = in_pixel_y >>> CHUNK_BITS;
  assign mask_x  = in_pixel_x & OFF_MASK;
  assign mask_y  = in_pixel_y & OFF_MASK;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      F_IDLE: begin
        if (accept) begin
          state_nxt = F_MUL;
        end
      end
      F_MUL:  state_nxt = F_BIAS;
      F_BIAS: state_nxt = F_RED;
      F_RED: begin
        if (dig_r == DIG_CNT_W'(NDIG - 1)) begin
          state_nxt = F_PUSH;
        end
      end
      F_PUSH: begin
        if (!q_full) begin
          state_nxt = accept ? F_MUL : F_IDLE;
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  // Outputs and digit counter.
  always_comb begin
    q_push  = (state_r == F_PUSH);
    q_item  = '{kx: kx_r, ky: ky_r, ox: ox_r, oy: oy_r, bucket: rem_r};
    dig_nxt = dig_r;
    if (state_r == F_BIAS) begin
      dig_nxt = '0;
    end else if (state_r == F_RED) begin
      dig_nxt = dig_r + 1'b1;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      dig_r   <= '0;
    end else begin
      state_r <= state_nxt;
      dig_r   <= dig_nxt;
    end
  end

  // Datapath: split, multiply, bias, then one remainder digit per cycle.
  always_ff @(posedge clk) begin
    if (accept) begin
      kx_r <= shift_x[KEY_W-1:0];
      ky_r <= shift_y[KEY_W-1:0];
      ox_r <= mask_x[OFF_W-1:0];
      oy_r <= mask_y[OFF_W-1:0];
    end
    if (state_r == F_MUL) begin
      prod_r <= kx_r * ky_r;
    end
    if (state_r == F_BIAS) begin
      u_r   <= prod_r + HASH_BIAS;
      rem_r <= '0;
    end
    if (state_r == F_RED) begin
      rem_r <= mod_step(rem_r, u_r[PROD_W-1 -: DIG_W]);
      u_r   <= u_r << DIG_W;
    end
  end

endmodule
`default_nettype wire

### src/csl_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// csl_queue: short item queue between front and back
// A small FIFO of classified items, so that front and back stall apart.
// ----------------------------------------------------------------------------
module csl_queue import csl_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      push,
  output logic           full,
  input  wire csl_item_t item_in,
  output logic           valid,
  input  wire logic      pop,
  output csl_item_t      item_out
);

  csl_item_t           mem [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]   cnt_r, cnt_nxt;
  logic                do_push, do_pop;

  assign full     = (cnt_r == QCNT_W'(QDEPTH));
  assign valid    = (cnt_r != '0);
  assign item_out = mem[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && valid;

  // Pointer and fill count updates.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= item_in;
    end
  end

endmodule
`default_nettype wire

### src/csl_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// csl_back: chain walk, slot allocation and result register
// Walks the bucket chain one link per cycle, allocates and links a slot on
// a miss, clears the bucket heads after reset and on a flush, and holds the
// finished result until it is taken.
// ----------------------------------------------------------------------------
module csl_back import csl_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              q_valid,
  output logic                   q_pop,
  input  wire csl_item_t         q_item,
  output logic                   init_busy,
  output logic                   out_empty,
  input  wire logic              out_pop,
  output logic [SLOT_W-1:0]      out_slot_index,
  output logic                   out_was_present,
  output logic                   out_table_flushed,
  output logic signed [KEY_W-1:0] out_chunk_x,
  output logic signed [KEY_W-1:0] out_chunk_y,
  output logic [OFF_W-1:0]       out_offset_x,
  output logic [OFF_W-1:0]       out_offset_y
);

  back_state_t state_r, state_nxt;

  // Control registers.
  logic [BKT_W-1:0]   clr_r, clr_nxt;
  logic               flush_pend_r, flush_pend_nxt;
  logic [SLOT_W-1:0]  used_r, used_nxt;
  logic [SLOT_AW-1:0] steps_r, steps_nxt;
  logic               out_valid_r, out_valid_nxt;

  // Working registers of the item under way.
  csl_item_t          itm_r, itm_nxt;
  logic [SLOT_W-1:0]  cur_r, cur_nxt;
  logic [SLOT_W-1:0]  head_r, head_nxt;
  logic               present_r, present_nxt;
  logic               flushed_r, flushed_nxt;

  // Result register.
  logic [SLOT_W-1:0]  out_slot_r;
  logic               out_present_r, out_flushed_r;
  logic [KEY_W-1:0]   out_kx_r, out_ky_r;
  logic [OFF_W-1:0]   out_ox_r, out_oy_r;
  logic               out_load;

  // Memory ports.
  logic               hd_we, hd_re;
  logic [BKT_W-1:0]   hd_waddr, hd_raddr;
  logic [SLOT_W-1:0]  hd_wdata, hd_rdata;
  logic               sl_we, sl_re;
  logic [SLOT_AW-1:0] sl_waddr, sl_raddr;
  logic [SLOT_DW-1:0] sl_wdata, sl_rdata;

  // Fields of the slot entry just read.
  logic [SLOT_W-1:0]  rd_link;
  logic [KEY_W-1:0]   rd_kx, rd_ky;
  logic               key_hit, last_step, clr_last, out_free;

  assign rd_link   = sl_rdata[SLOT_DW-1 -: SLOT_W];
  assign rd_kx     = sl_rdata[2*KEY_W-1 -: KEY_W];
  assign rd_ky     = sl_rdata[KEY_W-1:0];
  assign key_hit   = (rd_kx == itm_r.kx) && (rd_ky == itm_r.ky);
  assign last_step = (steps_r == SLOT_AW'(SLOTS - 1));
  assign clr_last  = (clr_r == BKT_W'(BUCKETS - 1));
  assign out_free  = !out_valid_r || out_pop;

  // Bucket heads and slot entries (link, key x, key y).
  csl_ram #(.WIDTH(SLOT_W), .DEPTH(BUCKETS)) u_head_ram (
    .clk   (clk),
    .we    (hd_we),
    .waddr (hd_waddr),
    .wdata (hd_wdata),
    .re    (hd_re),
    .raddr (hd_raddr),
    .rdata (hd_rdata)
  );

  csl_ram #(.WIDTH(SLOT_DW), .DEPTH(SLOTS)) u_slot_ram (
    .clk   (clk),
    .we    (sl_we),
    .waddr (sl_waddr),
    .wdata (sl_wdata),
    .re    (sl_re),
    .raddr (sl_raddr),
    .rdata (sl_rdata)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_CLEAR: begin
        if (clr_last) begin
          state_nxt = flush_pend_r ? B_LINK : B_IDLE;
        end
      end
      B_IDLE: begin
        if (q_valid) begin
          state_nxt = B_HEAD;
        end
      end
      B_HEAD: state_nxt = link_ok(hd_rdata) ? B_SLOT : B_ALLOC;
      B_SLOT: begin
        if (key_hit) begin
          state_nxt = B_DONE;
        end else if (last_step || !link_ok(rd_link)) begin
          state_nxt = B_ALLOC;
        end
      end
      B_ALLOC: state_nxt = (used_r >= SLOT_W'(SLOTS)) ? B_CLEAR : B_LINK;
      B_LINK:  state_nxt = B_DONE;
      B_DONE: begin
        if (out_free) begin
          state_nxt = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  // Memory controls and datapath updates.
  always_comb begin
    hd_we          = 1'b0;
    hd_waddr       = itm_r.bucket;
    hd_wdata       = cur_r;
    hd_re          = 1'b0;
    hd_raddr       = q_item.bucket;
    sl_we          = 1'b0;
    sl_waddr       = '0;
    sl_wdata       = {head_r, itm_r.kx, itm_r.ky};
    sl_re          = 1'b0;
    sl_raddr       = '0;
    q_pop          = 1'b0;
    out_load       = 1'b0;
    clr_nxt        = clr_r;
    flush_pend_nxt = flush_pend_r;
    used_nxt       = used_r;
    steps_nxt      = steps_r;
    itm_nxt        = itm_r;
    cur_nxt        = cur_r;
    head_nxt       = head_r;
    present_nxt    = present_r;
    flushed_nxt    = flushed_r;
    unique case (state_r)
      // Sweep the bucket heads to empty, one per cycle.
      B_CLEAR: begin
        hd_we    = 1'b1;
        hd_waddr = clr_r;
        hd_wdata = '0;
        clr_nxt  = clr_last ? '0 : clr_r + 1'b1;
      end
      // Take the next item and read its bucket head.
      B_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          itm_nxt   = q_item;
          hd_re     = 1'b1;
          steps_nxt = '0;
        end
      end
      // Start the walk at the head, if the bucket has a chain.
      B_HEAD: begin
        head_nxt = hd_rdata;
        cur_nxt  = hd_rdata;
        if (link_ok(hd_rdata)) begin
          sl_re    = 1'b1;
          sl_raddr = SLOT_AW'(hd_rdata - 1'b1);
        end
      end
      // Compare one stored key and follow its link on a mismatch.
      B_SLOT: begin
        if (key_hit) begin
          present_nxt = 1'b1;
          flushed_nxt = 1'b0;
        end else if (!last_step && link_ok(rd_link)) begin
          cur_nxt   = rd_link;
          steps_nxt = steps_r + 1'b1;
          sl_re     = 1'b1;
          sl_raddr  = SLOT_AW'(rd_link - 1'b1);
        end
      end
      // Allocate the next slot, or flush and restart at slot one.
      B_ALLOC: begin
        present_nxt = 1'b0;
        sl_we       = 1'b1;
        if (used_r >= SLOT_W'(SLOTS)) begin
          flushed_nxt    = 1'b1;
          used_nxt       = SLOT_W'(1);
          cur_nxt        = SLOT_W'(1);
          sl_waddr       = '0;
          sl_wdata       = {{SLOT_W{1'b0}}, itm_r.kx, itm_r.ky};
          flush_pend_nxt = 1'b1;
          clr_nxt        = '0;
        end else begin
          flushed_nxt = 1'b0;
          used_nxt    = used_r + 1'b1;
          cur_nxt     = used_r + 1'b1;
          sl_waddr    = SLOT_AW'(used_r);
        end
      end
      // Link the new slot at the head of its bucket.
      B_LINK: begin
        hd_we          = 1'b1;
        flush_pend_nxt = 1'b0;
      end
      // Hand the finished item to the result register.
      B_DONE: begin
        out_load = out_free;
      end
      default: begin
      end
    endcase
  end

  // Result register valid flag.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign init_busy = (state_r == B_CLEAR) && !flush_pend_r;

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= B_CLEAR;
      clr_r        <= '0;
      flush_pend_r <= 1'b0;
      used_r       <= '0;
      steps_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_r        <= clr_nxt;
      flush_pend_r <= flush_pend_nxt;
      used_r       <= used_nxt;
      steps_r      <= steps_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Working and result payload registers.
  always_ff @(posedge clk) begin
    itm_r     <= itm_nxt;
    cur_r     <= cur_nxt;
    head_r    <= head_nxt;
    present_r <= present_nxt;
    flushed_r <= flushed_nxt;
    if (out_load) begin
      out_slot_r    <= cur_r;
      out_present_r <= present_r;
      out_flushed_r <= flushed_r;
      out_kx_r      <= itm_r.kx;
      out_ky_r      <= itm_r.ky;
      out_ox_r      <= itm_r.ox;
      out_oy_r      <= itm_r.oy;
    end
  end

  assign out_empty         = !out_valid_r;
  assign out_slot_index    = out_slot_r;
  assign out_was_present   = out_present_r;
  assign out_table_flushed = out_flushed_r;
  assign out_chunk_x       = $signed(out_kx_r);
  assign out_chunk_y       = $signed(out_ky_r);
  assign out_offset_x      = out_ox_r;
  assign out_offset_y      = out_oy_r;

  // A flushed result always lands in slot one as a new allocation.
  a_flush_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_flushed_r |-> out_slot_r == SLOT_W'(1) && !out_present_r)
    else $error("flushed result not in slot one");

  // Every result names a slot inside the table.
  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_slot_r != '0 && out_slot_r <= SLOT_W'(SLOTS))
    else $error("result slot out of range");

  // The slot chosen by an allocation is the new fill count.
  a_alloc_used: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == B_ALLOC |=> cur_r == used_r)
    else $error("allocated slot differs from fill count");

  // A clearing pass caused by a flush ends by linking the new slot.
  a_flush_link: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == B_CLEAR && clr_last && flush_pend_r |=> state_r == B_LINK)
    else $error("flush pass did not return to linking");

endmodule
`default_nettype wire
